@@ hw/rtl/dllc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_pkg
// Shared types for the linked list cursor engine: request codes, node memory
// write enables and the result record.
// ----------------------------------------------------------------------------

package dllc_pkg;

    typedef enum logic [4:0] {
        REQ_CLEAR      = 5'd0,
        REQ_INS_FIRST  = 5'd1,
        REQ_INS_LAST   = 5'd2,
        REQ_CUR_FIRST  = 5'd3,
        REQ_CUR_LAST   = 5'd4,
        REQ_RD_FIRST   = 5'd5,
        REQ_RD_LAST    = 5'd6,
        REQ_DEL_FIRST  = 5'd7,
        REQ_DEL_LAST   = 5'd8,
        REQ_DEL_AFTER  = 5'd9,
        REQ_DEL_BEFORE = 5'd10,
        REQ_INS_AFTER  = 5'd11,
        REQ_INS_BEFORE = 5'd12,
        REQ_RD_CUR     = 5'd13,
        REQ_WR_CUR     = 5'd14,
        REQ_NEXT       = 5'd15,
        REQ_PREV       = 5'd16
    } req_e;

    // per-field write enables of one node
    typedef struct packed {
        logic data;
        logic prev;
        logic next;
    } node_we_t;

    typedef struct packed {
        logic               cursor_active;
        logic               error;
        logic signed [31:0] read_value;
    } result_t;

endpackage

@@ hw/rtl/dllc_node_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_node_mem
// Node pool storage: data, previous link and next link. One write port with
// per-field enables, one read port with registered data.
// ----------------------------------------------------------------------------

module dllc_node_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int LW    = 7
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [31:0]   rd_data,
    output logic [LW-1:0]        rd_prev,
    output logic [LW-1:0]        rd_next,
    input  dllc_pkg::node_we_t   we,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [31:0]   wr_data,
    input  logic [LW-1:0]        wr_prev,
    input  logic [LW-1:0]        wr_next
);

    logic signed [31:0] mem_data [DEPTH];
    logic [LW-1:0]      mem_prev [DEPTH];
    logic [LW-1:0]      mem_next [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.data)
        begin
            mem_data[wr_addr] <= wr_data;
        end
        if (we.prev)
        begin
            mem_prev[wr_addr] <= wr_prev;
        end
        if (we.next)
        begin
            mem_next[wr_addr] <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_data[rd_addr];
            rd_prev <= mem_prev[rd_addr];
            rd_next <= mem_next[rd_addr];
        end
    end

endmodule

@@ hw/rtl/dllc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllc_ctrl
// Request sequencer: holds head, tail, cursor, free list and fresh counter,
// walks the node memory with read, use and write-back steps.
// ----------------------------------------------------------------------------

module dllc_ctrl #(
    parameter int POOL_DEPTH = 64,
    parameter int AW         = 6,
    parameter int LW         = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [4:0]           in_req,
    input  logic signed [31:0]   in_value,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dllc_pkg::result_t    res,
    output logic                 mem_rd_en,
    output logic [AW-1:0]        mem_rd_addr,
    input  logic signed [31:0]   mem_rd_data,
    input  logic [LW-1:0]        mem_rd_prev,
    input  logic [LW-1:0]        mem_rd_next,
    output dllc_pkg::node_we_t   mem_we,
    output logic [AW-1:0]        mem_wr_addr,
    output logic signed [31:0]   mem_wr_data,
    output logic [LW-1:0]        mem_wr_prev,
    output logic [LW-1:0]        mem_wr_next
);

    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_ALLOC, S_FREE, S_INS, S_INSC,
        S_A, S_B, S_RD, S_WR, S_OUT
    } state_t;

    typedef enum logic {FLD_PREV, FLD_NEXT} fld_t;

    state_t              state_reg, state_next;
    dllc_pkg::req_e      req_reg, req_next;
    logic signed [31:0]  val_reg, val_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       tail_reg, tail_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       free_reg, free_next;
    logic [LW-1:0]       fresh_reg, fresh_next;
    logic [LW-1:0]       n_reg, n_next;      // node taken for an insert
    logic [LW-1:0]       a_reg, a_next;      // first node read
    logic [LW-1:0]       p_reg, p_next;      // neighbor to unlink
    logic                wa_valid_reg, wa_valid_next;
    logic [LW-1:0]       wa_addr_reg, wa_addr_next;
    fld_t                wa_fld_reg, wa_fld_next;
    logic [LW-1:0]       wa_val_reg, wa_val_next;
    logic                wb_valid_reg, wb_valid_next;
    logic [LW-1:0]       wb_addr_reg, wb_addr_next;
    fld_t                wb_fld_reg, wb_fld_next;
    logic [LW-1:0]       wb_val_reg, wb_val_next;
    logic signed [31:0]  rd_val_reg, rd_val_next;
    logic                err_reg, err_next;

    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        val_next      = val_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        free_next     = free_reg;
        fresh_next    = fresh_reg;
        n_next        = n_reg;
        a_next        = a_reg;
        p_next        = p_reg;
        wa_valid_next = wa_valid_reg;
        wa_addr_next  = wa_addr_reg;
        wa_fld_next   = wa_fld_reg;
        wa_val_next   = wa_val_reg;
        wb_valid_next = wb_valid_reg;
        wb_addr_next  = wb_addr_reg;
        wb_fld_next   = wb_fld_reg;
        wb_val_next   = wb_val_reg;
        rd_val_next   = rd_val_reg;
        err_next      = err_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        mem_we        = '0;
        mem_wr_addr   = '0;
        mem_wr_data   = val_reg;
        mem_wr_prev   = '0;
        mem_wr_next   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next      = dllc_pkg::req_e'(in_req);
                    val_next      = in_value;
                    rd_val_next   = '0;
                    err_next      = 1'b0;
                    wa_valid_next = 1'b0;
                    wb_valid_next = 1'b0;
                    state_next    = S_START;
                end
            end

            S_START:
            begin
                state_next = S_OUT;
                unique case (req_reg)
                    dllc_pkg::REQ_CLEAR:
                    begin
                        if (head_reg != NULL_LINK)
                        begin
                            mem_we.next = 1'b1;
                            mem_wr_addr = tail_reg[AW-1:0];
                            mem_wr_next = free_reg;
                            free_next   = head_reg;
                        end
                        head_next = NULL_LINK;
                        tail_next = NULL_LINK;
                        cur_next  = NULL_LINK;
                    end
                    dllc_pkg::REQ_INS_FIRST, dllc_pkg::REQ_INS_LAST:
                    begin
                        state_next = S_ALLOC;
                    end
                    dllc_pkg::REQ_INS_AFTER, dllc_pkg::REQ_INS_BEFORE:
                    begin
                        if (cur_reg != NULL_LINK)
                        begin
                            state_next = S_ALLOC;
                        end
                    end
                    dllc_pkg::REQ_CUR_FIRST: cur_next = head_reg;
                    dllc_pkg::REQ_CUR_LAST:  cur_next = tail_reg;
                    dllc_pkg::REQ_RD_FIRST:
                    begin
                        if (head_reg == NULL_LINK)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg[AW-1:0];
                            state_next  = S_RD;
                        end
                    end
                    dllc_pkg::REQ_RD_LAST:
                    begin
                        if (tail_reg == NULL_LINK)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = tail_reg[AW-1:0];
                            state_next  = S_RD;
                        end
                    end
                    dllc_pkg::REQ_RD_CUR:
                    begin
                        if (cur_reg == NULL_LINK)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = cur_reg[AW-1:0];
                            state_next  = S_RD;
                        end
                    end
                    dllc_pkg::REQ_DEL_FIRST:
                    begin
                        if (head_reg != NULL_LINK)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_reg[AW-1:0];
                            a_next      = head_reg;
                            state_next  = S_A;
                        end
                    end
                    dllc_pkg::REQ_DEL_LAST:
                    begin
                        if (tail_reg != NULL_LINK)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = tail_reg[AW-1:0];
                            a_next      = tail_reg;
                            state_next  = S_A;
                        end
                    end
                    dllc_pkg::REQ_DEL_AFTER:
                    begin
                        if (cur_reg != NULL_LINK && cur_reg != tail_reg)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = cur_reg[AW-1:0];
                            a_next      = cur_reg;
                            state_next  = S_A;
                        end
                    end
                    dllc_pkg::REQ_DEL_BEFORE:
                    begin
                        if (cur_reg != NULL_LINK && cur_reg != head_reg)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = cur_reg[AW-1:0];
                            a_next      = cur_reg;
                            state_next  = S_A;
                        end
                    end
                    dllc_pkg::REQ_WR_CUR:
                    begin
                        if (cur_reg != NULL_LINK)
                        begin
                            mem_we.data = 1'b1;
                            mem_wr_addr = cur_reg[AW-1:0];
                        end
                    end
                    dllc_pkg::REQ_NEXT, dllc_pkg::REQ_PREV:
                    begin
                        if (cur_reg != NULL_LINK)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = cur_reg[AW-1:0];
                            a_next      = cur_reg;
                            state_next  = S_A;
                        end
                    end
                    default: ;
                endcase
            end

            // free list first, then never-used nodes
            S_ALLOC:
            begin
                if (free_reg != NULL_LINK)
                begin
                    n_next      = free_reg;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = free_reg[AW-1:0];
                    state_next  = S_FREE;
                end
                else if (fresh_reg != NULL_LINK)
                begin
                    n_next     = fresh_reg;
                    fresh_next = fresh_reg + LW'(1);
                    state_next = S_INS;
                end
                else
                begin
                    err_next   = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_FREE:
            begin
                free_next  = mem_rd_next;
                state_next = S_INS;
            end

            S_INS:
            begin
                state_next = S_WR;
                unique case (req_reg)
                    dllc_pkg::REQ_INS_FIRST:
                    begin
                        mem_we      = '{data: 1'b1, prev: 1'b1, next: 1'b1};
                        mem_wr_addr = n_reg[AW-1:0];
                        mem_wr_prev = NULL_LINK;
                        mem_wr_next = head_reg;
                        if (head_reg != NULL_LINK)
                        begin
                            wa_valid_next = 1'b1;
                            wa_addr_next  = head_reg;
                            wa_fld_next   = FLD_PREV;
                            wa_val_next   = n_reg;
                        end
                        else
                        begin
                            tail_next = n_reg;
                        end
                        head_next = n_reg;
                    end
                    dllc_pkg::REQ_INS_LAST:
                    begin
                        mem_we      = '{data: 1'b1, prev: 1'b1, next: 1'b1};
                        mem_wr_addr = n_reg[AW-1:0];
                        mem_wr_prev = tail_reg;
                        mem_wr_next = NULL_LINK;
                        if (tail_reg != NULL_LINK)
                        begin
                            wa_valid_next = 1'b1;
                            wa_addr_next  = tail_reg;
                            wa_fld_next   = FLD_NEXT;
                            wa_val_next   = n_reg;
                        end
                        else
                        begin
                            head_next = n_reg;
                        end
                        tail_next = n_reg;
                    end
                    dllc_pkg::REQ_INS_AFTER, dllc_pkg::REQ_INS_BEFORE:
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cur_reg[AW-1:0];
                        state_next  = S_INSC;
                    end
                    default: state_next = S_OUT;
                endcase
            end

            // cursor node record is on the read port
            S_INSC:
            begin
                state_next = S_WR;
                unique case (req_reg)
                    dllc_pkg::REQ_INS_AFTER:
                    begin
                        mem_we      = '{data: 1'b1, prev: 1'b1, next: 1'b1};
                        mem_wr_addr = n_reg[AW-1:0];
                        mem_wr_prev = cur_reg;
                        mem_wr_next = mem_rd_next;
                        wa_valid_next = 1'b1;
                        if (cur_reg == tail_reg)
                        begin
                            tail_next    = n_reg;
                            wa_addr_next = cur_reg;
                            wa_fld_next  = FLD_NEXT;
                            wa_val_next  = n_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_next;
                            wa_fld_next   = FLD_PREV;
                            wa_val_next   = n_reg;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = cur_reg;
                            wb_fld_next   = FLD_NEXT;
                            wb_val_next   = n_reg;
                        end
                    end
                    dllc_pkg::REQ_INS_BEFORE:
                    begin
                        mem_we      = '{data: 1'b1, prev: 1'b1, next: 1'b1};
                        mem_wr_addr = n_reg[AW-1:0];
                        mem_wr_prev = mem_rd_prev;
                        mem_wr_next = cur_reg;
                        wa_valid_next = 1'b1;
                        if (cur_reg == head_reg)
                        begin
                            head_next    = n_reg;
                            wa_addr_next = cur_reg;
                            wa_fld_next  = FLD_PREV;
                            wa_val_next  = n_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_prev;
                            wa_fld_next   = FLD_NEXT;
                            wa_val_next   = n_reg;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = cur_reg;
                            wb_fld_next   = FLD_PREV;
                            wb_val_next   = n_reg;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end

            // record of a_reg is on the read port
            S_A:
            begin
                state_next = S_OUT;
                unique case (req_reg)
                    dllc_pkg::REQ_DEL_FIRST:
                    begin
                        if (cur_reg == a_reg)
                        begin
                            cur_next = NULL_LINK;
                        end
                        wa_valid_next = 1'b1;
                        if (tail_reg == a_reg)
                        begin
                            tail_next    = NULL_LINK;
                            wa_addr_next = a_reg;
                            wa_fld_next  = FLD_NEXT;
                            wa_val_next  = free_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_next;
                            wa_fld_next   = FLD_PREV;
                            wa_val_next   = NULL_LINK;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = a_reg;
                            wb_fld_next   = FLD_NEXT;
                            wb_val_next   = free_reg;
                        end
                        head_next  = mem_rd_next;
                        free_next  = a_reg;
                        state_next = S_WR;
                    end
                    dllc_pkg::REQ_DEL_LAST:
                    begin
                        if (cur_reg == a_reg)
                        begin
                            cur_next = NULL_LINK;
                        end
                        wa_valid_next = 1'b1;
                        if (head_reg == a_reg)
                        begin
                            head_next    = NULL_LINK;
                            wa_addr_next = a_reg;
                            wa_fld_next  = FLD_NEXT;
                            wa_val_next  = free_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_prev;
                            wa_fld_next   = FLD_NEXT;
                            wa_val_next   = NULL_LINK;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = a_reg;
                            wb_fld_next   = FLD_NEXT;
                            wb_val_next   = free_reg;
                        end
                        tail_next  = mem_rd_prev;
                        free_next  = a_reg;
                        state_next = S_WR;
                    end
                    dllc_pkg::REQ_DEL_AFTER:
                    begin
                        p_next      = mem_rd_next;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = mem_rd_next[AW-1:0];
                        state_next  = S_B;
                    end
                    dllc_pkg::REQ_DEL_BEFORE:
                    begin
                        p_next      = mem_rd_prev;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = mem_rd_prev[AW-1:0];
                        state_next  = S_B;
                    end
                    dllc_pkg::REQ_NEXT: cur_next = mem_rd_next;
                    dllc_pkg::REQ_PREV: cur_next = mem_rd_prev;
                    default: ;
                endcase
            end

            // record of the neighbor p_reg is on the read port
            S_B:
            begin
                state_next    = S_WR;
                free_next     = p_reg;
                wa_valid_next = 1'b1;
                mem_wr_addr   = a_reg[AW-1:0];
                unique case (req_reg)
                    dllc_pkg::REQ_DEL_AFTER:
                    begin
                        mem_we.next = 1'b1;
                        mem_wr_next = mem_rd_next;
                        if (p_reg == tail_reg)
                        begin
                            tail_next    = a_reg;
                            wa_addr_next = p_reg;
                            wa_fld_next  = FLD_NEXT;
                            wa_val_next  = free_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_next;
                            wa_fld_next   = FLD_PREV;
                            wa_val_next   = a_reg;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = p_reg;
                            wb_fld_next   = FLD_NEXT;
                            wb_val_next   = free_reg;
                        end
                    end
                    default:
                    begin
                        mem_we.prev = 1'b1;
                        mem_wr_prev = mem_rd_prev;
                        if (p_reg == head_reg)
                        begin
                            head_next    = a_reg;
                            wa_addr_next = p_reg;
                            wa_fld_next  = FLD_NEXT;
                            wa_val_next  = free_reg;
                        end
                        else
                        begin
                            wa_addr_next  = mem_rd_prev;
                            wa_fld_next   = FLD_NEXT;
                            wa_val_next   = a_reg;
                            wb_valid_next = 1'b1;
                            wb_addr_next  = p_reg;
                            wb_fld_next   = FLD_NEXT;
                            wb_val_next   = free_reg;
                        end
                    end
                endcase
            end

            // drain queued link writes, one per cycle
            S_WR:
            begin
                if (wa_valid_reg)
                begin
                    mem_wr_addr   = wa_addr_reg[AW-1:0];
                    mem_we.prev   = (wa_fld_reg == FLD_PREV);
                    mem_we.next   = (wa_fld_reg == FLD_NEXT);
                    mem_wr_prev   = wa_val_reg;
                    mem_wr_next   = wa_val_reg;
                    wa_valid_next = wb_valid_reg;
                    wa_addr_next  = wb_addr_reg;
                    wa_fld_next   = wb_fld_reg;
                    wa_val_next   = wb_val_reg;
                    wb_valid_next = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_RD:
            begin
                rd_val_next = mem_rd_data;
                state_next  = S_OUT;
            end

            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign res.read_value    = rd_val_reg;
    assign res.error         = err_reg;
    assign res.cursor_active = (cur_reg != NULL_LINK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            req_reg      <= dllc_pkg::REQ_CLEAR;
            val_reg      <= '0;
            head_reg     <= NULL_LINK;
            tail_reg     <= NULL_LINK;
            cur_reg      <= NULL_LINK;
            free_reg     <= NULL_LINK;
            fresh_reg    <= '0;
            n_reg        <= '0;
            a_reg        <= '0;
            p_reg        <= '0;
            wa_valid_reg <= 1'b0;
            wa_addr_reg  <= '0;
            wa_fld_reg   <= FLD_PREV;
            wa_val_reg   <= '0;
            wb_valid_reg <= 1'b0;
            wb_addr_reg  <= '0;
            wb_fld_reg   <= FLD_PREV;
            wb_val_reg   <= '0;
            rd_val_reg   <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            val_reg      <= val_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cur_reg      <= cur_next;
            free_reg     <= free_next;
            fresh_reg    <= fresh_next;
            n_reg        <= n_next;
            a_reg        <= a_next;
            p_reg        <= p_next;
            wa_valid_reg <= wa_valid_next;
            wa_addr_reg  <= wa_addr_next;
            wa_fld_reg   <= wa_fld_next;
            wa_val_reg   <= wa_val_next;
            wb_valid_reg <= wb_valid_next;
            wb_addr_reg  <= wb_addr_next;
            wb_fld_reg   <= wb_fld_next;
            wb_val_reg   <= wb_val_next;
            rd_val_reg   <= rd_val_next;
            err_reg      <= err_next;
        end
    end

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NULL_LINK)
        else $error("fresh counter past pool depth");

    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) == (tail_reg == NULL_LINK))
        else $error("head and tail disagree on empty list");

    a_empty_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) |-> (cur_reg == NULL_LINK))
        else $error("cursor active on empty list");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (mem_we == '0))
        else $error("node read and write in the same cycle");

endmodule

@@ hw/rtl/doubly_linked_list_cursor_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine_core
// Bounded doubly linked list of signed 32-bit values with a cursor, kept in a
// node pool memory with previous/next links and a free list.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Carries
// s_axis    in   one request: req_type and value
// m_axis    out  one result per request: read_value, error, cursor_active
//
// Each request runs through a chain of dependent node memory accesses (one
// read or one write per cycle, read data registered); a request that changes
// links then passes the write-back step, which issues the queued link writes
// in order and leaves once none is left. An insert at the cursor that takes a
// node from the free list is the longest; moves to an end, clear and requests
// that change nothing the shortest. One request is in work at a time.
// Reset (rst_n low) empties the list; node memory holds no reset value.
// A result waits in the output register; the next request is taken while it
// waits, but cannot finish until the register is free.

module doubly_linked_list_cursor_engine_core #(
    parameter int POOL_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [4:0] req_type, [36:5] value, [39:37] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] read_value, [32] error,
                                        // [33] cursor_active, [39:34] zero
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int LW = $clog2(POOL_DEPTH + 1);   // one extra code for null

    logic                 res_valid;
    logic                 res_ready;
    dllc_pkg::result_t    res;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic signed [31:0]   mem_rd_data;
    logic [LW-1:0]        mem_rd_prev;
    logic [LW-1:0]        mem_rd_next;
    dllc_pkg::node_we_t   mem_we;
    logic [AW-1:0]        mem_wr_addr;
    logic signed [31:0]   mem_wr_data;
    logic [LW-1:0]        mem_wr_prev;
    logic [LW-1:0]        mem_wr_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    dllc_pkg::result_t    out_data_reg, out_data_next;

    dllc_ctrl #(
        .POOL_DEPTH (POOL_DEPTH),
        .AW         (AW),
        .LW         (LW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (s_axis_tdata[4:0]),
        .in_value    (s_axis_tdata[36:5]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_rd_prev (mem_rd_prev),
        .mem_rd_next (mem_rd_next),
        .mem_we      (mem_we),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_wr_prev (mem_wr_prev),
        .mem_wr_next (mem_wr_next)
    );

    dllc_node_mem #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_node_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .rd_prev (mem_rd_prev),
        .rd_next (mem_rd_next),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .wr_prev (mem_wr_prev),
        .wr_next (mem_wr_next)
    );

    // result moves in when the register is empty or drains this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg.cursor_active, out_data_reg.error,
                            out_data_reg.read_value};

endmodule

@@ tb/doubly_linked_list_cursor_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine_core_tb
// Drives list requests into the cursor engine and checks every result against
// a behavioral copy of the list, node pool and free list kept in the bench.
// Directed corner requests come first, then random traffic in fill, drain and
// cursor-walk bursts, under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------

module doubly_linked_list_cursor_engine_core_tb;

    localparam int          POOL      = 64;
    localparam int unsigned NIL       = POOL;  // null link code
    localparam int          HOLD_LEN  = 300;   // long receiver hold-off, cycles

    // behavioral list model and the queue of results it still owes
    class list_scoreboard;
        logic [31:0]       data_mem [POOL];
        int unsigned       prev_mem [POOL];
        int unsigned       next_mem [POOL];
        int unsigned       head, tail, cur, free_head, fresh;
        dllc_pkg::result_t owed [$];
        int                mismatches;

        function new();
            head = NIL; tail = NIL; cur = NIL; free_head = NIL; fresh = 0;
            mismatches = 0;
        endfunction

        function int unsigned nxt(int unsigned i);
            return (i < NIL) ? next_mem[i] : NIL;
        endfunction

        function int unsigned prv(int unsigned i);
            return (i < NIL) ? prev_mem[i] : NIL;
        endfunction

        function void set_nxt(int unsigned i, int unsigned v);
            if (i < NIL) next_mem[i] = v;
        endfunction

        function void set_prv(int unsigned i, int unsigned v);
            if (i < NIL) prev_mem[i] = v;
        endfunction

        // free list first, then never-used nodes; NIL when the pool is full
        function int unsigned alloc_node();
            int unsigned n;
            if (free_head != NIL) begin
                n = free_head;
                free_head = nxt(n);
                return n;
            end
            if (fresh < NIL) begin
                n = fresh;
                fresh++;
                return n;
            end
            return NIL;
        endfunction

        function void free_node(int unsigned n);
            if (n >= NIL) return;
            set_nxt(n, free_head);
            free_head = n;
        endfunction

        // apply one accepted request and queue the result it must produce
        function void note_request(logic [4:0] req, logic [31:0] val);
            dllc_pkg::result_t r;
            int unsigned       c, n, p;
            r = '0;
            c = cur;
            case (req)
                dllc_pkg::REQ_CLEAR: begin
                    if (head != NIL) begin
                        set_nxt(tail, free_head);
                        free_head = head;
                    end
                    head = NIL; tail = NIL; cur = NIL;
                end
                dllc_pkg::REQ_INS_FIRST: begin
                    n = alloc_node();
                    if (n == NIL) r.error = 1'b1;
                    else begin
                        data_mem[n] = val;
                        set_prv(n, NIL);
                        set_nxt(n, head);
                        if (head != NIL) set_prv(head, n); else tail = n;
                        head = n;
                    end
                end
                dllc_pkg::REQ_INS_LAST: begin
                    n = alloc_node();
                    if (n == NIL) r.error = 1'b1;
                    else begin
                        data_mem[n] = val;
                        set_nxt(n, NIL);
                        set_prv(n, tail);
                        if (tail != NIL) set_nxt(tail, n); else head = n;
                        tail = n;
                    end
                end
                dllc_pkg::REQ_CUR_FIRST: cur = head;
                dllc_pkg::REQ_CUR_LAST:  cur = tail;
                dllc_pkg::REQ_RD_FIRST: begin
                    if (head == NIL) r.error = 1'b1; else r.read_value = data_mem[head];
                end
                dllc_pkg::REQ_RD_LAST: begin
                    if (tail == NIL) r.error = 1'b1; else r.read_value = data_mem[tail];
                end
                dllc_pkg::REQ_DEL_FIRST: begin
                    n = head;
                    if (n != NIL) begin
                        if (cur == n) cur = NIL;
                        if (tail == n) tail = NIL; else set_prv(nxt(n), NIL);
                        head = nxt(n);
                        free_node(n);
                    end
                end
                dllc_pkg::REQ_DEL_LAST: begin
                    n = tail;
                    if (n != NIL) begin
                        if (cur == n) cur = NIL;
                        if (head == n) head = NIL; else set_nxt(prv(n), NIL);
                        tail = prv(n);
                        free_node(n);
                    end
                end
                dllc_pkg::REQ_DEL_AFTER: begin
                    if (c != NIL && c != tail) begin
                        p = nxt(c);
                        set_nxt(c, nxt(p));
                        if (p == tail) tail = c; else set_prv(nxt(p), c);
                        free_node(p);
                    end
                end
                dllc_pkg::REQ_DEL_BEFORE: begin
                    if (c != NIL && c != head) begin
                        p = prv(c);
                        set_prv(c, prv(p));
                        if (p == head) head = c; else set_nxt(prv(p), c);
                        free_node(p);
                    end
                end
                dllc_pkg::REQ_INS_AFTER: begin
                    if (c != NIL) begin
                        n = alloc_node();
                        if (n == NIL) r.error = 1'b1;
                        else begin
                            data_mem[n] = val;
                            set_nxt(n, nxt(c));
                            set_prv(n, c);
                            if (c == tail) tail = n; else set_prv(nxt(c), n);
                            set_nxt(c, n);
                        end
                    end
                end
                dllc_pkg::REQ_INS_BEFORE: begin
                    if (c != NIL) begin
                        n = alloc_node();
                        if (n == NIL) r.error = 1'b1;
                        else begin
                            data_mem[n] = val;
                            set_prv(n, prv(c));
                            set_nxt(n, c);
                            if (c == head) head = n; else set_nxt(prv(c), n);
                            set_prv(c, n);
                        end
                    end
                end
                dllc_pkg::REQ_RD_CUR: begin
                    if (c == NIL) r.error = 1'b1; else r.read_value = data_mem[c];
                end
                dllc_pkg::REQ_WR_CUR: if (c != NIL) data_mem[c] = val;
                dllc_pkg::REQ_NEXT:   if (c != NIL) cur = nxt(c);
                dllc_pkg::REQ_PREV:   if (c != NIL) cur = prv(c);
                default: ;
            endcase
            r.cursor_active = (cur != NIL);
            owed.push_back(r);
        endfunction

        function void check_result(logic [39:0] tdata);
            dllc_pkg::result_t got, want;
            got.read_value    = tdata[31:0];
            got.error         = tdata[32];
            got.cursor_active = tdata[33];
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", tdata);
                return;
            end
            want = owed.pop_front();
            if (got.read_value !== want.read_value || got.error !== want.error ||
                got.cursor_active !== want.cursor_active) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp val=%h err=%b act=%b, ",
                              "got val=%h err=%b act=%b"},
                             want.read_value, want.error, want.cursor_active,
                             got.read_value, got.error, got.cursor_active);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [4:0] req_type, [36:5] value, [39:37] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] read_value, [32] error, [33] cursor_active

    list_scoreboard board;
    int send_idle_pct;    // chance per slot that the sender idles
    int recv_stall_pct;   // chance per cycle that the receiver stalls
    int hold_req_count;   // bumped by the driver to ask for a long hold-off

    doubly_linked_list_cursor_engine_core #(.POOL_DEPTH(POOL)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_count != hold_seen)
            begin
                hold_seen = hold_req_count;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // offer one request; tvalid stays high into the next one unless idling
    task automatic send_request(logic [4:0] req, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, val, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(req, val);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // bias: 0 fill the pool, 1 drain it, 2 walk and edit at the cursor
    function automatic logic [4:0] pick_request(int bias);
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return 5'($urandom_range(17, 31));   // unknown codes
        if (roll < 4) return dllc_pkg::REQ_CLEAR;
        roll = $urandom_range(99);
        case (bias)
            0: begin
                if (roll < 35) return dllc_pkg::REQ_INS_LAST;
                if (roll < 60) return dllc_pkg::REQ_INS_FIRST;
                if (roll < 75) return dllc_pkg::REQ_INS_AFTER;
                if (roll < 85) return dllc_pkg::REQ_INS_BEFORE;
                if (roll < 90) return dllc_pkg::REQ_CUR_FIRST;
                return 5'($urandom_range(dllc_pkg::REQ_CUR_LAST, dllc_pkg::REQ_PREV));
            end
            1: begin
                if (roll < 25) return dllc_pkg::REQ_DEL_FIRST;
                if (roll < 50) return dllc_pkg::REQ_DEL_LAST;
                if (roll < 62) return dllc_pkg::REQ_DEL_AFTER;
                if (roll < 74) return dllc_pkg::REQ_DEL_BEFORE;
                if (roll < 80) return dllc_pkg::REQ_CUR_LAST;
                return 5'($urandom_range(dllc_pkg::REQ_INS_FIRST, dllc_pkg::REQ_PREV));
            end
            default: begin
                if (roll < 10) return dllc_pkg::REQ_CUR_FIRST;
                if (roll < 20) return dllc_pkg::REQ_CUR_LAST;
                if (roll < 35) return dllc_pkg::REQ_NEXT;
                if (roll < 48) return dllc_pkg::REQ_PREV;
                if (roll < 58) return dllc_pkg::REQ_RD_CUR;
                if (roll < 66) return dllc_pkg::REQ_WR_CUR;
                return 5'($urandom_range(dllc_pkg::REQ_INS_FIRST, dllc_pkg::REQ_PREV));
            end
        endcase
    endfunction

    initial
    begin : timeout
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int k;
        int bias;
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req_count = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list and inactive-cursor cases, ends, unknown codes
        send_request(dllc_pkg::REQ_RD_FIRST,   32'h0);
        send_request(dllc_pkg::REQ_RD_LAST,    32'h0);
        send_request(dllc_pkg::REQ_RD_CUR,     32'h0);
        send_request(dllc_pkg::REQ_DEL_FIRST,  32'h0);
        send_request(dllc_pkg::REQ_DEL_LAST,   32'h0);
        send_request(dllc_pkg::REQ_CUR_FIRST,  32'h0);
        send_request(dllc_pkg::REQ_NEXT,       32'h0);
        send_request(dllc_pkg::REQ_INS_AFTER,  32'h1234_5678);
        send_request(dllc_pkg::REQ_WR_CUR,     32'hdead_beef);
        send_request(dllc_pkg::REQ_INS_FIRST,  32'h7fff_ffff);
        send_request(dllc_pkg::REQ_INS_LAST,   32'h8000_0000);
        send_request(dllc_pkg::REQ_INS_FIRST,  32'hffff_ffff);
        send_request(dllc_pkg::REQ_CUR_FIRST,  32'h0);
        send_request(dllc_pkg::REQ_DEL_BEFORE, 32'h0);   // cursor on first element
        send_request(dllc_pkg::REQ_INS_BEFORE, 32'haaaa_aaaa);
        send_request(dllc_pkg::REQ_PREV,       32'h0);
        send_request(dllc_pkg::REQ_RD_CUR,     32'h0);
        send_request(dllc_pkg::REQ_INS_AFTER,  32'h5555_5555);
        send_request(dllc_pkg::REQ_DEL_AFTER,  32'h0);
        send_request(dllc_pkg::REQ_CUR_LAST,   32'h0);
        send_request(dllc_pkg::REQ_DEL_AFTER,  32'h0);   // cursor on last element
        send_request(dllc_pkg::REQ_WR_CUR,     32'h0);
        send_request(dllc_pkg::REQ_DEL_LAST,   32'h0);   // deletes the cursor element
        send_request(5'd31,                    32'hffff_ffff);
        send_request(dllc_pkg::REQ_CLEAR,      32'h0);

        // random: four idling patterns, bursts that fill, drain and walk
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (phase == 0)
                hold_req_count++;   // block backs up while requests keep coming
            bias = 0;
            for (k = 0; k < 150; k++)
            begin
                if (k % 50 == 0)
                    bias = (k == 0) ? 0 : $urandom_range(2);
                send_request(pick_request(bias), pick_value());
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        @(posedge clk);
        repeat (30) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dllc_pkg.sv
hw/rtl/dllc_node_mem.sv
hw/rtl/dllc_ctrl.sv
hw/rtl/doubly_linked_list_cursor_engine_core.sv
tb/doubly_linked_list_cursor_engine_core_tb.sv
